// File: sv/pbpc_pkg.sv
// Shared types, constants and codes of the packet buffer pool with cache.
package pbpc_pkg;

  localparam int NUM_BUFFERS = 1024;
  localparam int CACHE_DEPTH = 64;
  localparam int ALIGN_BYTES = 64;

  localparam int ID_W     = 10;
  localparam int CNT_W    = 11;
  localparam int CCNT_W   = 7;
  localparam int CAP_W    = 17;
  localparam int OFF_W    = 26;
  localparam int ARENA_W  = 27;
  localparam int FAIL_W   = 32;
  localparam int PADDR_W  = $clog2(NUM_BUFFERS);
  localparam int CADDR_W  = $clog2(CACHE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 4;
  localparam int IN_PAD_W    = IN_TDATA_W - ID_W;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (ID_W + OFF_W + 2 * CNT_W + FAIL_W + CCNT_W + ARENA_W);

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LIMIT = 2'd2;

  localparam logic [CAP_W-1:0]  CAP_MIN          = 17'd64;
  localparam logic [CAP_W-1:0]  CAP_MAX          = 17'd65549;
  localparam logic [CNT_W-1:0]  RST_POOL_COUNT   = 11'd1024;
  localparam logic [CAP_W-1:0]  RST_CAPACITY     = 17'd2048;
  localparam logic [CCNT_W-1:0] RST_CACHE_LIMIT  = 7'd32;

  typedef enum logic [2:0] {
    KIND_POOL_ACQ      = 3'd0,
    KIND_POOL_REL      = 3'd1,
    KIND_CACHE_ACQ     = 3'd2,
    KIND_CACHE_RECYCLE = 3'd3,
    KIND_CACHE_FLUSH   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_POOL_ACQ,
    OP_RELEASE,
    OP_CACHE_ACQ,
    OP_RECYCLE,
    OP_FLUSH
  } op_t;

  typedef enum logic [1:0] {
    OWN_FREE   = 2'd0,
    OWN_HOST   = 2'd1,
    OWN_CACHED = 2'd2
  } own_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_ID    = 2'd1,
    ERR_OWNERSHIP = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP_WAIT,
    ST_CPOP_WAIT,
    ST_OWN_WAIT,
    ST_SPILL_WAIT,
    ST_CACHE_PUSH,
    ST_FLUSH,
    ST_DONE
  } bstate_t;

  typedef struct packed {
    op_t             op;
    logic            bad_id;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    logic             clearing;
    logic [CNT_W-1:0] pool_count;
  } back_status_t;

  typedef struct packed {
    logic               granted;
    logic [ID_W-1:0]    result_id;
    logic [OFF_W-1:0]   result_offset;
    err_t               error_code;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   in_use_count;
    logic [FAIL_W-1:0]  failure_total;
    logic [CCNT_W-1:0]  cached_count;
    logic [ARENA_W-1:0] arena_bytes;
  } result_t;

endpackage

// File: sv/packet_buffer_pool_with_cache_core.sv
// Top level of the packet buffer pool with a local buffer cache.
//
// Requests arrive on the in_ stream, one item per request: acquire or release
// a pool buffer, acquire or recycle through the cache, or flush the cache.
// Every request gives exactly one result item on the out_ stream, carrying
// the granted buffer, its offset, an error code and the pool statistics.
// Registers are written on the cfg_ channel; the user must write them only
// while no request is outstanding, as the block does not enforce it. A queue
// of two items separates the request decode from the stack engine. The engine
// works on one item at a time, from the queue to the result register. After
// reset and after every pool count write, a pass rewrites every entry of the
// free stack and the ownership table, one entry per cycle; in_tready stays low
// until it ends. A result waits in the output register while out_tready is
// low; the queue keeps accepting until it is full.
module packet_buffer_pool_with_cache_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pbpc_pkg::IN_TDATA_W-1:0]     in_tdata,   // buffer_id, zero padding
  input  logic [pbpc_pkg::IN_TUSER_W-1:0]     in_tuser,   // kind, buffer_present
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_id, result_offset, free_count, in_use_count, failure_total,
  // cached_count, arena_bytes, zero padding
  output logic [pbpc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [pbpc_pkg::OUT_TUSER_W-1:0]    out_tuser,  // granted, error_code
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pbpc_pkg::back_status_t status;
  pbpc_pkg::req_t         req;
  pbpc_pkg::result_t      res;
  logic                   req_valid;
  logic                   req_pop;

  pbpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .status    (status),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  pbpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res       (res),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .status    (status)
  );

  assign out_tdata = {{pbpc_pkg::OUT_PAD_W{1'b0}}, res.arena_bytes, res.cached_count,
                      res.failure_total, res.in_use_count, res.free_count,
                      res.result_offset, res.result_id};
  assign out_tuser = {res.error_code, res.granted};

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> !in_tready)
    else $error("request taken during the table clearing pass");

  a_grant_without_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.granted) |-> (res.error_code == pbpc_pkg::ERR_NONE))
    else $error("granted result carries an error code");

  a_no_grant_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.granted) |-> (res.result_id == '0 && res.result_offset == '0))
    else $error("result without a grant carries a buffer");

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.free_count <= pbpc_pkg::CNT_W'(pbpc_pkg::NUM_BUFFERS) &&
                    res.cached_count <= pbpc_pkg::CCNT_W'(pbpc_pkg::CACHE_DEPTH)))
    else $error("stack fill out of range");
`endif

endmodule

// File: sv/pbpc_front.sv
// Front end: takes request items, classifies them and queues them for the back end.
module pbpc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pbpc_pkg::IN_TDATA_W-1:0]     in_tdata,   // buffer_id, zero padding
  input  logic [pbpc_pkg::IN_TUSER_W-1:0]     in_tuser,   // kind, buffer_present
  input  pbpc_pkg::back_status_t              status,
  output logic                                req_valid,
  output pbpc_pkg::req_t                      req,
  input  logic                                req_pop
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  pbpc_pkg::req_t          q_data_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  pbpc_pkg::req_t          cls;
  pbpc_pkg::kind_t         kind;
  logic                    present;
  logic [pbpc_pkg::ID_W-1:0] bid;
  logic                    push;
  logic                    pop;

  assign kind    = pbpc_pkg::kind_t'(in_tuser[2:0]);
  assign present = in_tuser[3];
  assign bid     = in_tdata[pbpc_pkg::ID_W-1:0];

  always_comb begin
    cls.id     = bid;
    cls.bad_id = !present || ({1'b0, bid} >= status.pool_count);
    case (kind)
      pbpc_pkg::KIND_POOL_ACQ:      cls.op = pbpc_pkg::OP_POOL_ACQ;
      pbpc_pkg::KIND_POOL_REL:      cls.op = pbpc_pkg::OP_RELEASE;
      pbpc_pkg::KIND_CACHE_ACQ:     cls.op = pbpc_pkg::OP_CACHE_ACQ;
      pbpc_pkg::KIND_CACHE_RECYCLE: cls.op = pbpc_pkg::OP_RECYCLE;
      pbpc_pkg::KIND_CACHE_FLUSH:   cls.op = pbpc_pkg::OP_FLUSH;
      default:                      cls.op = pbpc_pkg::OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH)) && !status.clearing;
  assign push      = in_tvalid && in_tready;
  assign pop       = req_pop && req_valid;
  assign req_valid = (cnt_r != '0);
  assign req       = q_data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: sv/pbpc_back.sv
// Back end: configuration registers, pool and cache stacks, ownership table and results.
module pbpc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  input  pbpc_pkg::req_t                    req,
  output logic                              req_pop,
  output pbpc_pkg::result_t                 res,
  output logic                              res_valid,
  input  logic                              res_ready,
  output pbpc_pkg::back_status_t            status
);

  localparam int ID_W    = pbpc_pkg::ID_W;
  localparam int CNT_W   = pbpc_pkg::CNT_W;
  localparam int CCNT_W  = pbpc_pkg::CCNT_W;
  localparam int CAP_W   = pbpc_pkg::CAP_W;
  localparam int FAIL_W  = pbpc_pkg::FAIL_W;
  localparam int PADDR_W = pbpc_pkg::PADDR_W;
  localparam int CADDR_W = pbpc_pkg::CADDR_W;
  localparam int NUM     = pbpc_pkg::NUM_BUFFERS;
  localparam int DEPTH   = pbpc_pkg::CACHE_DEPTH;

  function automatic logic [CAP_W-1:0] round_stride(input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] sum;
    sum = {1'b0, cap} + (CAP_W + 1)'(pbpc_pkg::ALIGN_BYTES - 1);
    return CAP_W'(sum & ~((CAP_W + 1)'(pbpc_pkg::ALIGN_BYTES - 1)));
  endfunction

  // Memories
  logic [ID_W-1:0]         pool_mem [NUM];
  pbpc_pkg::own_t          own_mem [NUM];
  logic [ID_W-1:0]         cache_mem [DEPTH];

  logic                    pool_we, pool_re;
  logic [PADDR_W-1:0]      pool_waddr, pool_raddr;
  logic [ID_W-1:0]         pool_wdata, pool_rd_r;
  logic                    own_we, own_re;
  logic [PADDR_W-1:0]      own_waddr, own_raddr;
  pbpc_pkg::own_t          own_wdata, own_rd_r;
  logic                    cache_we, cache_re;
  logic [CADDR_W-1:0]      cache_waddr, cache_raddr;
  logic [ID_W-1:0]         cache_wdata, cache_rd_r;

  // Control and state
  pbpc_pkg::bstate_t       state_r, state_nxt;
  logic [CNT_W-1:0]        pcount_r;
  logic [CAP_W-1:0]        stride_r;
  logic [CCNT_W-1:0]       lim_r;
  logic [pbpc_pkg::ARENA_W-1:0] arena_r;
  logic [CNT_W+CAP_W-1:0]  arena_full;
  logic [CNT_W-1:0]        ptop_r, ptop_nxt, ptop_dec;
  logic [CCNT_W-1:0]       ctop_r, ctop_nxt, ctop_dec;
  logic [FAIL_W-1:0]       fail_r, fail_nxt;
  logic [PADDR_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [CCNT_W-1:0]       flush_idx_r, flush_idx_nxt;
  logic                    flush_pend_r, flush_pend_nxt;
  pbpc_pkg::req_t          cur_r, cur_nxt;
  logic                    granted_r, granted_nxt;
  logic [ID_W-1:0]         rid_r, rid_nxt;
  pbpc_pkg::err_t          err_r, err_nxt;
  pbpc_pkg::result_t       out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;
  logic [ID_W+CAP_W-1:0]   offset_full;
  logic                    push_en;
  logic [ID_W-1:0]         push_id;
  logic                    pool_pop_go;

  // Configuration decode
  logic                    wr_pool_count, wr_capacity, wr_cache_limit;
  logic [CNT_W-1:0]        pc_in, pc_sat;
  logic [CAP_W-1:0]        cap_in, cap_sat;
  logic [CCNT_W-1:0]       lim_in, lim_sat;

  assign cfg_ready      = 1'b1;
  assign wr_pool_count  = cfg_valid && (cfg_index == pbpc_pkg::CFG_POOL_COUNT);
  assign wr_capacity    = cfg_valid && (cfg_index == pbpc_pkg::CFG_CAPACITY);
  assign wr_cache_limit = cfg_valid && (cfg_index == pbpc_pkg::CFG_CACHE_LIMIT);

  assign pc_in  = cfg_data[CNT_W-1:0];
  assign cap_in = cfg_data[CAP_W-1:0];
  assign lim_in = cfg_data[CCNT_W-1:0];

  always_comb begin
    pc_sat = pc_in;
    if (pc_in == '0) begin
      pc_sat = CNT_W'(1);
    end else if (pc_in > CNT_W'(NUM)) begin
      pc_sat = CNT_W'(NUM);
    end
    cap_sat = cap_in;
    if (cap_in < pbpc_pkg::CAP_MIN) begin
      cap_sat = pbpc_pkg::CAP_MIN;
    end else if (cap_in > pbpc_pkg::CAP_MAX) begin
      cap_sat = pbpc_pkg::CAP_MAX;
    end
    lim_sat = lim_in;
    if (lim_in == '0) begin
      lim_sat = CCNT_W'(1);
    end else if (lim_in > CCNT_W'(DEPTH)) begin
      lim_sat = CCNT_W'(DEPTH);
    end
  end

  assign ptop_dec = ptop_r - 1'b1;
  assign ctop_dec = ctop_r - 1'b1;
  assign out_load = !out_valid_r || res_ready;
  assign pool_pop_go = (ptop_r != '0);

  assign status.clearing   = (state_r == pbpc_pkg::ST_CLEAR);
  assign status.pool_count = pcount_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbpc_pkg::ST_CLEAR: begin
        if (clr_idx_r == PADDR_W'(NUM - 1)) begin
          state_nxt = pbpc_pkg::ST_IDLE;
        end
      end
      pbpc_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req.op)
            pbpc_pkg::OP_POOL_ACQ: begin
              state_nxt = pool_pop_go ? pbpc_pkg::ST_POP_WAIT : pbpc_pkg::ST_DONE;
            end
            pbpc_pkg::OP_CACHE_ACQ: begin
              if (ctop_r != '0) begin
                state_nxt = pbpc_pkg::ST_CPOP_WAIT;
              end else begin
                state_nxt = pool_pop_go ? pbpc_pkg::ST_POP_WAIT : pbpc_pkg::ST_DONE;
              end
            end
            pbpc_pkg::OP_RELEASE, pbpc_pkg::OP_RECYCLE: begin
              state_nxt = req.bad_id ? pbpc_pkg::ST_DONE : pbpc_pkg::ST_OWN_WAIT;
            end
            pbpc_pkg::OP_FLUSH: state_nxt = pbpc_pkg::ST_FLUSH;
            default:            state_nxt = pbpc_pkg::ST_DONE;
          endcase
        end
      end
      pbpc_pkg::ST_POP_WAIT, pbpc_pkg::ST_CPOP_WAIT: begin
        state_nxt = pbpc_pkg::ST_DONE;
      end
      pbpc_pkg::ST_OWN_WAIT: begin
        if (own_rd_r != pbpc_pkg::OWN_HOST || cur_r.op == pbpc_pkg::OP_RELEASE) begin
          state_nxt = pbpc_pkg::ST_DONE;
        end else if (ctop_r >= lim_r) begin
          state_nxt = pbpc_pkg::ST_SPILL_WAIT;
        end else begin
          state_nxt = pbpc_pkg::ST_CACHE_PUSH;
        end
      end
      pbpc_pkg::ST_SPILL_WAIT: state_nxt = pbpc_pkg::ST_CACHE_PUSH;
      pbpc_pkg::ST_CACHE_PUSH: state_nxt = pbpc_pkg::ST_DONE;
      pbpc_pkg::ST_FLUSH: begin
        if (!flush_pend_r && flush_idx_r >= ctop_r) begin
          state_nxt = pbpc_pkg::ST_DONE;
        end
      end
      pbpc_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = pbpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbpc_pkg::ST_IDLE;
    endcase
    if (wr_pool_count) begin
      state_nxt = pbpc_pkg::ST_CLEAR;
    end
  end

  // Datapath and memory control
  always_comb begin
    pool_we        = 1'b0;
    pool_waddr     = '0;
    pool_wdata     = '0;
    pool_re        = 1'b0;
    pool_raddr     = ptop_dec[PADDR_W-1:0];
    own_we         = 1'b0;
    own_waddr      = '0;
    own_wdata      = pbpc_pkg::OWN_FREE;
    own_re         = 1'b0;
    own_raddr      = req.id[PADDR_W-1:0];
    cache_we       = 1'b0;
    cache_waddr    = ctop_r[CADDR_W-1:0];
    cache_wdata    = cur_r.id;
    cache_re       = 1'b0;
    cache_raddr    = ctop_dec[CADDR_W-1:0];
    req_pop        = 1'b0;
    push_en        = 1'b0;
    push_id        = '0;
    ptop_nxt       = ptop_r;
    ctop_nxt       = ctop_r;
    fail_nxt       = fail_r;
    clr_idx_nxt    = clr_idx_r;
    flush_idx_nxt  = flush_idx_r;
    flush_pend_nxt = flush_pend_r;
    cur_nxt        = cur_r;
    granted_nxt    = granted_r;
    rid_nxt        = rid_r;
    err_nxt        = err_r;
    out_nxt        = out_r;
    out_valid_nxt  = res_ready ? 1'b0 : out_valid_r;

    case (state_r)
      pbpc_pkg::ST_CLEAR: begin
        pool_we     = 1'b1;
        pool_waddr  = clr_idx_r;
        pool_wdata  = ({1'b0, clr_idx_r} < pcount_r) ? ID_W'(clr_idx_r) : '0;
        own_we      = 1'b1;
        own_waddr   = clr_idx_r;
        own_wdata   = pbpc_pkg::OWN_FREE;
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      pbpc_pkg::ST_IDLE: begin
        if (req_valid) begin
          req_pop     = 1'b1;
          cur_nxt     = req;
          granted_nxt = 1'b0;
          rid_nxt     = '0;
          err_nxt     = pbpc_pkg::ERR_NONE;
          case (req.op)
            pbpc_pkg::OP_POOL_ACQ, pbpc_pkg::OP_CACHE_ACQ: begin
              if (req.op == pbpc_pkg::OP_CACHE_ACQ && ctop_r != '0) begin
                cache_re = 1'b1;
                ctop_nxt = ctop_dec;
              end else if (pool_pop_go) begin
                pool_re  = 1'b1;
                ptop_nxt = ptop_dec;
              end else if (fail_r != '1) begin
                fail_nxt = fail_r + 1'b1;
              end
            end
            pbpc_pkg::OP_RELEASE, pbpc_pkg::OP_RECYCLE: begin
              if (req.bad_id) begin
                err_nxt = pbpc_pkg::ERR_BAD_ID;
              end else begin
                own_re = 1'b1;
              end
            end
            pbpc_pkg::OP_FLUSH: begin
              flush_idx_nxt  = '0;
              flush_pend_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      pbpc_pkg::ST_POP_WAIT: begin
        granted_nxt = 1'b1;
        rid_nxt     = pool_rd_r;
        own_we      = 1'b1;
        own_waddr   = pool_rd_r[PADDR_W-1:0];
        own_wdata   = pbpc_pkg::OWN_HOST;
      end
      pbpc_pkg::ST_CPOP_WAIT: begin
        granted_nxt = 1'b1;
        rid_nxt     = cache_rd_r;
        own_we      = 1'b1;
        own_waddr   = cache_rd_r[PADDR_W-1:0];
        own_wdata   = pbpc_pkg::OWN_HOST;
      end
      pbpc_pkg::ST_OWN_WAIT: begin
        if (own_rd_r != pbpc_pkg::OWN_HOST) begin
          err_nxt = pbpc_pkg::ERR_OWNERSHIP;
        end else if (cur_r.op == pbpc_pkg::OP_RELEASE) begin
          push_en = 1'b1;
          push_id = cur_r.id;
        end else if (ctop_r >= lim_r) begin
          cache_re = 1'b1;
          ctop_nxt = ctop_dec;
        end
      end
      pbpc_pkg::ST_SPILL_WAIT: begin
        push_en = 1'b1;
        push_id = cache_rd_r;
      end
      pbpc_pkg::ST_CACHE_PUSH: begin
        if (ctop_r < CCNT_W'(DEPTH)) begin
          cache_we  = 1'b1;
          ctop_nxt  = ctop_r + 1'b1;
          own_we    = 1'b1;
          own_waddr = cur_r.id[PADDR_W-1:0];
          own_wdata = pbpc_pkg::OWN_CACHED;
        end
      end
      pbpc_pkg::ST_FLUSH: begin
        if (flush_pend_r) begin
          push_en = 1'b1;
          push_id = cache_rd_r;
        end
        if (flush_idx_r < ctop_r) begin
          cache_re       = 1'b1;
          cache_raddr    = flush_idx_r[CADDR_W-1:0];
          flush_idx_nxt  = flush_idx_r + 1'b1;
          flush_pend_nxt = 1'b1;
        end else begin
          flush_pend_nxt = 1'b0;
          if (!flush_pend_r) begin
            ctop_nxt = '0;
          end
        end
      end
      pbpc_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt         = 1'b1;
          out_nxt.granted       = granted_r;
          out_nxt.result_id     = rid_r;
          out_nxt.result_offset = offset_full[pbpc_pkg::OFF_W-1:0];
          out_nxt.error_code    = err_r;
          out_nxt.free_count    = ptop_r;
          out_nxt.in_use_count  = pcount_r - ptop_r;
          out_nxt.failure_total = fail_r;
          out_nxt.cached_count  = ctop_r;
          out_nxt.arena_bytes   = arena_r;
        end
      end
      default: begin
      end
    endcase

    if (push_en) begin
      own_we    = 1'b1;
      own_waddr = push_id[PADDR_W-1:0];
      own_wdata = pbpc_pkg::OWN_FREE;
      if (ptop_r < CNT_W'(NUM)) begin
        pool_we    = 1'b1;
        pool_waddr = ptop_r[PADDR_W-1:0];
        pool_wdata = push_id;
        ptop_nxt   = ptop_r + 1'b1;
      end
    end
  end

  assign offset_full = rid_r * stride_r;
  assign arena_full  = pcount_r * stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pbpc_pkg::ST_CLEAR;
      pcount_r     <= pbpc_pkg::RST_POOL_COUNT;
      stride_r     <= round_stride(pbpc_pkg::RST_CAPACITY);
      lim_r        <= pbpc_pkg::RST_CACHE_LIMIT;
      ptop_r       <= pbpc_pkg::RST_POOL_COUNT;
      ctop_r       <= '0;
      fail_r       <= '0;
      clr_idx_r    <= '0;
      flush_idx_r  <= '0;
      flush_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptop_r       <= ptop_nxt;
      ctop_r       <= ctop_nxt;
      fail_r       <= fail_nxt;
      clr_idx_r    <= clr_idx_nxt;
      flush_idx_r  <= flush_idx_nxt;
      flush_pend_r <= flush_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (wr_pool_count) begin
        pcount_r  <= pc_sat;
        ptop_r    <= pc_sat;
        ctop_r    <= '0;
        fail_r    <= '0;
        clr_idx_r <= '0;
      end
      if (wr_capacity) begin
        stride_r <= round_stride(cap_sat);
      end
      if (wr_cache_limit) begin
        lim_r <= lim_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    granted_r <= granted_nxt;
    rid_r     <= rid_nxt;
    err_r     <= err_nxt;
    out_r     <= out_nxt;
    arena_r   <= arena_full[pbpc_pkg::ARENA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    if (pool_re) begin
      pool_rd_r <= pool_mem[pool_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_waddr] <= own_wdata;
    end
    if (own_re) begin
      own_rd_r <= own_mem[own_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    if (cache_re) begin
      cache_rd_r <= cache_mem[cache_raddr];
    end
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;

endmodule

// File: tb/buffer_pool_checker.sv
// Checker that predicts every result of the buffer pool and compares it with the block's output.
`timescale 1ns / 100ps

module buffer_pool_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [pbpc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [pbpc_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [pbpc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic [pbpc_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  n_checked,
  output int                                  n_granted,
  output int                                  n_bad_id,
  output int                                  n_wrong_owner,
  output int                                  n_empty_pool
);

  localparam int NUM_BUFFERS = pbpc_pkg::NUM_BUFFERS;
  localparam int CACHE_DEPTH = pbpc_pkg::CACHE_DEPTH;
  localparam int ALIGN_BYTES = pbpc_pkg::ALIGN_BYTES;
  localparam int ID_W        = pbpc_pkg::ID_W;
  localparam int CNT_W       = pbpc_pkg::CNT_W;
  localparam int CCNT_W      = pbpc_pkg::CCNT_W;
  localparam int CAP_W       = pbpc_pkg::CAP_W;
  localparam int OFF_W       = pbpc_pkg::OFF_W;
  localparam int ARENA_W     = pbpc_pkg::ARENA_W;
  localparam int FAIL_W      = pbpc_pkg::FAIL_W;
  localparam int OUT_PAD_W   = pbpc_pkg::OUT_PAD_W;

  logic [ID_W-1:0]    free_stack [NUM_BUFFERS];
  logic [CNT_W-1:0]   free_top;
  logic [ID_W-1:0]    cache_ids [CACHE_DEPTH];
  logic [CCNT_W-1:0]  cache_fill;
  pbpc_pkg::own_t     owner [NUM_BUFFERS];
  logic [FAIL_W-1:0]  empty_acq_total;
  logic [CNT_W-1:0]   pool_size;
  logic [CAP_W-1:0]   capacity;
  logic [CCNT_W-1:0]  cache_cap_raw;
  pbpc_pkg::result_t  pending_results [$];

  function automatic void restock();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      free_stack[i] = (i < pool_size) ? ID_W'(i) : '0;
      owner[i] = pbpc_pkg::OWN_FREE;
    end
    free_top = pool_size;
    cache_fill = '0;
    empty_acq_total = '0;
  endfunction

  function automatic void pool_return(input logic [ID_W-1:0] id);
    owner[id] = pbpc_pkg::OWN_FREE;
    if (free_top < NUM_BUFFERS) begin
      free_stack[free_top] = id;
      free_top++;
    end
  endfunction

  function automatic logic pool_take(output logic [ID_W-1:0] got);
    got = '0;
    if (free_top == 0) begin
      if (empty_acq_total != '1) empty_acq_total++;
      return 1'b0;
    end
    free_top--;
    got = free_stack[free_top];
    owner[got] = pbpc_pkg::OWN_HOST;
    return 1'b1;
  endfunction

  function automatic pbpc_pkg::result_t serve_request(input logic [2:0] kind,
                                                      input logic present,
                                                      input logic [ID_W-1:0] id);
    pbpc_pkg::result_t r;
    logic [ID_W-1:0]   got;
    int unsigned       lim;
    longint unsigned   stride;
    r = '0;
    got = '0;
    lim = cache_cap_raw;
    if (lim < 1) lim = 1;
    if (lim > CACHE_DEPTH) lim = CACHE_DEPTH;
    stride = ((longint'(capacity) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    case (kind)
      pbpc_pkg::KIND_POOL_ACQ: r.granted = pool_take(got);
      pbpc_pkg::KIND_CACHE_ACQ: begin
        if (cache_fill == 0) begin
          r.granted = pool_take(got);
        end else begin
          cache_fill--;
          got = cache_ids[cache_fill];
          owner[got] = pbpc_pkg::OWN_HOST;
          r.granted = 1'b1;
        end
      end
      pbpc_pkg::KIND_POOL_REL, pbpc_pkg::KIND_CACHE_RECYCLE: begin
        if (!present || id >= pool_size) begin
          r.error_code = pbpc_pkg::ERR_BAD_ID;
          n_bad_id++;
        end else if (owner[id] != pbpc_pkg::OWN_HOST) begin
          r.error_code = pbpc_pkg::ERR_OWNERSHIP;
          n_wrong_owner++;
        end else if (kind == pbpc_pkg::KIND_POOL_REL) begin
          pool_return(id);
        end else begin
          // A full cache gives its newest buffer back to the pool first.
          if (cache_fill >= lim) begin
            cache_fill--;
            pool_return(cache_ids[cache_fill]);
          end
          cache_ids[cache_fill] = id;
          cache_fill++;
          owner[id] = pbpc_pkg::OWN_CACHED;
        end
      end
      pbpc_pkg::KIND_CACHE_FLUSH: begin
        for (int i = 0; i < cache_fill; i++) pool_return(cache_ids[i]);
        cache_fill = '0;
      end
      default: ;
    endcase
    if (r.granted) begin
      r.result_id = got;
      r.result_offset = OFF_W'(got * stride);
      n_granted++;
    end else if (kind == pbpc_pkg::KIND_POOL_ACQ || kind == pbpc_pkg::KIND_CACHE_ACQ) begin
      n_empty_pool++;
    end
    r.free_count = free_top;
    r.in_use_count = pool_size - free_top;
    r.failure_total = empty_acq_total;
    r.cached_count = cache_fill;
    r.arena_bytes = ARENA_W'(pool_size * stride);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", n_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    pbpc_pkg::result_t    want;
    logic [OUT_PAD_W-1:0] pad;
    logic [ID_W-1:0]      got_id;
    logic [OFF_W-1:0]     got_off;
    logic [CNT_W-1:0]     got_free;
    logic [CNT_W-1:0]     got_in_use;
    logic [FAIL_W-1:0]    got_fail;
    logic [CCNT_W-1:0]    got_cached;
    logic [ARENA_W-1:0]   got_arena;
    logic                 got_granted;
    logic [1:0]           got_err;
    logic [CNT_W-1:0]     new_count;
    if (!rst_n) begin
      pool_size = pbpc_pkg::RST_POOL_COUNT;
      capacity = pbpc_pkg::RST_CAPACITY;
      cache_cap_raw = pbpc_pkg::RST_CACHE_LIMIT;
      restock();
      pending_results.delete();
      fail_count = 0;
      n_checked = 0;
      n_granted = 0;
      n_bad_id = 0;
      n_wrong_owner = 0;
      n_empty_pool = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        {pad, got_arena, got_cached, got_fail, got_in_use, got_free, got_off, got_id} = out_tdata;
        {got_err, got_granted} = out_tuser;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item: tuser 0x%0h, tdata 0x%0h", out_tuser, out_tdata);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          check_field("granted", want.granted, got_granted);
          check_field("result_id", want.result_id, got_id);
          check_field("result_offset", want.result_offset, got_off);
          check_field("error_code", want.error_code, got_err);
          check_field("free_count", want.free_count, got_free);
          check_field("in_use_count", want.in_use_count, got_in_use);
          check_field("failure_total", want.failure_total, got_fail);
          check_field("cached_count", want.cached_count, got_cached);
          check_field("arena_bytes", want.arena_bytes, got_arena);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pbpc_pkg::CFG_POOL_COUNT: begin
            new_count = cfg_data[CNT_W-1:0];
            if (new_count == 0) new_count = 1;
            if (new_count > NUM_BUFFERS) new_count = CNT_W'(NUM_BUFFERS);
            pool_size = new_count;
            restock();
          end
          pbpc_pkg::CFG_CAPACITY: begin
            if (cfg_data < pbpc_pkg::CAP_MIN) capacity = pbpc_pkg::CAP_MIN;
            else if (cfg_data > pbpc_pkg::CAP_MAX) capacity = pbpc_pkg::CAP_MAX;
            else capacity = cfg_data;
          end
          pbpc_pkg::CFG_CACHE_LIMIT: cache_cap_raw = cfg_data[CCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_results.insert(pending_results.size(),
                               serve_request(in_tuser[2:0], in_tuser[3], in_tdata[ID_W-1:0]));
      pending = pending_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top that drives requests and register writes into the buffer pool and gives the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_BUFFERS = pbpc_pkg::NUM_BUFFERS;
  localparam int ID_W        = pbpc_pkg::ID_W;
  localparam int CNT_W       = pbpc_pkg::CNT_W;
  localparam int IN_PAD_W    = pbpc_pkg::IN_PAD_W;
  localparam int CFG_IDX_W   = pbpc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = pbpc_pkg::CFG_DATA_W;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [pbpc_pkg::IN_TDATA_W-1:0]      in_tdata = '0;
  logic [pbpc_pkg::IN_TUSER_W-1:0]      in_tuser = '0;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [pbpc_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic [pbpc_pkg::OUT_TUSER_W-1:0]     out_tuser;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [CFG_IDX_W-1:0]                 cfg_index = pbpc_pkg::CFG_POOL_COUNT;
  logic [CFG_DATA_W-1:0]                cfg_data = '0;

  int fail_count;
  int pending;
  int n_checked;
  int n_granted;
  int n_bad_id;
  int n_wrong_owner;
  int n_empty_pool;
  int in_idle_pct = 23;
  int out_idle_pct = 72;
  int cur_pool = NUM_BUFFERS;
  int n_sent = 0;
  int n_writes = 0;

  packet_buffer_pool_with_cache_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  buffer_pool_checker pool_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .n_checked     (n_checked),
    .n_granted     (n_granted),
    .n_bad_id      (n_bad_id),
    .n_wrong_owner (n_wrong_owner),
    .n_empty_pool  (n_empty_pool)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly ids just below the pool size, where the stack hands buffers out, plus foreign ids.
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    int span;
    r = $urandom_range(99);
    span = (cur_pool > 16) ? 15 : cur_pool - 1;
    if (r < 75) return ID_W'(cur_pool - 1 - $urandom_range(0, span));
    if (r < 85 && cur_pool < NUM_BUFFERS) return ID_W'($urandom_range(cur_pool, NUM_BUFFERS - 1));
    return ID_W'($urandom_range(0, NUM_BUFFERS - 1));
  endfunction

  task automatic send_req(input logic [2:0] kind, input logic present,
                          input logic [ID_W-1:0] id);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{IN_PAD_W{1'b0}}, id};
    in_tuser <= {present, kind};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pool, input logic [CFG_DATA_W-1:0] cap,
                           input logic [CFG_DATA_W-1:0] lim);
    int p;
    wait_idle();
    write_reg(pbpc_pkg::CFG_POOL_COUNT, pool);
    write_reg(pbpc_pkg::CFG_CAPACITY, cap);
    write_reg(pbpc_pkg::CFG_CACHE_LIMIT, lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
    p = pool[CNT_W-1:0];
    cur_pool = (p < 1) ? 1 : (p > NUM_BUFFERS) ? NUM_BUFFERS : p;
  endtask

  task automatic random_burst(input int n);
    int drain_at;
    int r;
    drain_at = $urandom_range(n / 4, 3 * n / 4);
    for (int i = 0; i < n; i++) begin
      if (i == drain_at) wait_idle();
      r = $urandom_range(99);
      if (r < 20)
        send_req(pbpc_pkg::KIND_POOL_ACQ, 1'($urandom), ID_W'($urandom));
      else if (r < 40)
        send_req(pbpc_pkg::KIND_CACHE_ACQ, 1'($urandom), ID_W'($urandom));
      else if (r < 64)
        send_req(pbpc_pkg::KIND_CACHE_RECYCLE, $urandom_range(99) >= 5, pick_id());
      else if (r < 88)
        send_req(pbpc_pkg::KIND_POOL_REL, $urandom_range(99) >= 5, pick_id());
      else if (r < 95)
        send_req(pbpc_pkg::KIND_CACHE_FLUSH, 1'($urandom), ID_W'($urandom));
      else
        send_req(3'($urandom_range(pbpc_pkg::KIND_CACHE_FLUSH + 1, 7)), 1'($urandom),
                 ID_W'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default registers: acquire, cache fallback, double hand-backs, null buffers, unknown kinds, flush.
    send_req(pbpc_pkg::KIND_POOL_ACQ, 1'b1, '0);
    send_req(pbpc_pkg::KIND_CACHE_ACQ, 1'b1, '1);
    send_req(pbpc_pkg::KIND_CACHE_RECYCLE, 1'b1, 10'd1023);
    send_req(pbpc_pkg::KIND_CACHE_RECYCLE, 1'b1, 10'd1023);
    send_req(pbpc_pkg::KIND_POOL_REL, 1'b1, 10'd1023);
    send_req(pbpc_pkg::KIND_CACHE_RECYCLE, 1'b1, 10'd1022);
    send_req(pbpc_pkg::KIND_CACHE_ACQ, 1'b0, '0);
    send_req(pbpc_pkg::KIND_POOL_REL, 1'b1, 10'd1022);
    send_req(pbpc_pkg::KIND_POOL_REL, 1'b1, 10'd1022);
    send_req(pbpc_pkg::KIND_POOL_REL, 1'b0, 10'd1023);
    send_req(pbpc_pkg::KIND_CACHE_RECYCLE, 1'b0, 10'd0);
    for (int k = pbpc_pkg::KIND_CACHE_FLUSH + 1; k < 8; k++) send_req(3'(k), k[0], ID_W'(k));
    send_req(pbpc_pkg::KIND_CACHE_FLUSH, 1'b1, '0);
    send_req(pbpc_pkg::KIND_CACHE_FLUSH, 1'b0, '1);

    // Two buffers and a cache of one: empty pool, spill on recycle, foreign id.
    configure(17'd2, 17'd2047, 17'd1);
    send_req(pbpc_pkg::KIND_POOL_ACQ, 1'b1, '0);
    send_req(pbpc_pkg::KIND_CACHE_ACQ, 1'b1, '0);
    send_req(pbpc_pkg::KIND_POOL_ACQ, 1'b1, '0);
    send_req(pbpc_pkg::KIND_CACHE_ACQ, 1'b1, '0);
    send_req(pbpc_pkg::KIND_CACHE_RECYCLE, 1'b1, 10'd1);
    send_req(pbpc_pkg::KIND_CACHE_RECYCLE, 1'b1, 10'd0);
    send_req(pbpc_pkg::KIND_POOL_REL, 1'b1, 10'd1023);
    send_req(pbpc_pkg::KIND_POOL_ACQ, 1'b1, '0);
    send_req(pbpc_pkg::KIND_CACHE_FLUSH, 1'b1, '0);
    send_req(pbpc_pkg::KIND_POOL_REL, 1'b1, 10'd0);

    configure(17'd4, 17'd0, 17'd1);
    random_burst(130);
    configure(17'h1FFFF, 17'h1FFFF, 17'h0007F);
    random_burst(130);

    in_idle_pct = 72;
    out_idle_pct = 23;
    configure(17'd16, 17'd65, 17'h00080);
    random_burst(130);
    configure(17'd0, 17'd1500, 17'd3);
    random_burst(60);

    in_idle_pct = 0;
    out_idle_pct = 0;
    configure(17'd40, 17'd65549, 17'd64);
    random_burst(200);

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Sent %0d requests and %0d register writes under three handshake idling patterns.",
             n_sent, n_writes);
    $display("Checked %0d results: %0d grants, %0d empty-pool acquires, %0d bad ids, %0d %s",
             n_checked, n_granted, n_empty_pool, n_bad_id, n_wrong_owner, "ownership errors.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pbpc_pkg.sv
sv/pbpc_front.sv
sv/pbpc_back.sv
sv/packet_buffer_pool_with_cache_core.sv
tb/buffer_pool_checker.sv
tb/tb_top.sv
